### sv/asymmetric_lowpass_clamp_filter_macros.svh
// assertion helpers used by the filter rtl file
`ifndef ASYMMETRIC_LOWPASS_CLAMP_FILTER_MACROS_SVH
`define ASYMMETRIC_LOWPASS_CLAMP_FILTER_MACROS_SVH

// checked only out of reset
`define ALCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ALCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/alcf_pkg.sv
`timescale 1ns / 1ps
package alcf_pkg;

  localparam int DATA_W     = 32;
  localparam int RATE_W     = 24;
  localparam int STALE_W    = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int MAG_W      = DATA_W + 1;
  localparam int A_W        = 40;
  localparam int MUL_A_W    = 24;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int PROD_W     = 56;
  localparam int QUO_W      = 47;

  localparam int DIVISOR    = 1000;
  localparam int REM_W      = 10;
  localparam int DIGIT_BITS = 4;
  localparam int DIV_STEPS  = PROD_W / DIGIT_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [RATE_W-1:0]        RISE_RATE_RST = 24'd65536;
  localparam logic [RATE_W-1:0]        FALL_RATE_RST = 24'd65536;
  localparam logic signed [DATA_W-1:0] DATA_MAX      = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN      = 32'sh8000_0000;
  localparam logic [STALE_W-1:0]       STALE_MS_RST  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_RATE  = 3'd0,
    CFG_FALL_RATE  = 3'd1,
    CFG_MAX_LIMIT  = 3'd2,
    CFG_MIN_LIMIT  = 3'd3,
    CFG_MAX_ENABLE = 3'd4,
    CFG_MIN_ENABLE = 3'd5,
    CFG_STALE_MS   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_sts_t;

endpackage

### sv/asymmetric_lowpass_clamp_filter.sv
// channel  direction  signals
// in       request    in_valid in_ready in_sample in_timestamp_ms
// out      result     out_valid out_ready out_filtered
// cfg      write      cfg_valid cfg_ready cfg_index cfg_data
//
// a filtered request makes four passes through the shared 24x17 multiplier
//   and 14 radix-16 steps dividing by 1000 before its result is ready
// a restart request (first after reset or stale gap) goes straight to S_DONE with the raw sample
// in_ready is high only in idle; one result may wait in the output register
// synchronous active-low reset clears filter state and loads register defaults
`timescale 1ns / 1ps
`include "asymmetric_lowpass_clamp_filter_macros.svh"
module asymmetric_lowpass_clamp_filter import alcf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [DATA_W-1:0]    in_sample,
  input  logic        [DATA_W-1:0]    in_timestamp_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    out_filtered,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [DATA_W-1:0]    cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIFF  = 10'b00_0000_0010,
    S_MUL0  = 10'b00_0000_0100,
    S_MUL1  = 10'b00_0000_1000,
    S_MUL2  = 10'b00_0001_0000,
    S_MUL3  = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_SUM   = 10'b00_1000_0000,
    S_CLAMP = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [RATE_W-1:0]        rise_r, fall_r;
  logic signed [DATA_W-1:0] max_lim_r, min_lim_r;
  logic                     max_en_r, min_en_r;
  logic [STALE_W-1:0]       stale_r;

  logic signed [DATA_W-1:0] fo_r, fo_nxt;
  logic [DATA_W-1:0]        last_r, last_nxt;
  logic                     primed_r, primed_nxt;

  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic [STALE_W-1:0]       e_r, e_nxt;
  logic                     restart_r, restart_nxt;
  logic [RATE_W-1:0]        rate_r, rate_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         m_r, m_nxt;
  logic [A_W-1:0]           a_r, a_nxt;
  logic [PROD_W-1:0]        q_r, q_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;

  logic                     in_fire;
  logic [DATA_W-1:0]        elapsed;
  logic                     stale_gap;
  logic signed [MAG_W-1:0]  diff;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [MUL_P_W-1:0]       prod;
  logic signed [QUO_W+1:0]  step_s, sum_s;
  logic signed [DATA_W-1:0] sat_v, clamp_v;
  div_req_t                 div_req;
  div_sts_t                 div_sts;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

  assign elapsed   = in_timestamp_ms - last_r;
  assign stale_gap = (elapsed > {{(DATA_W-STALE_W){1'b0}}, stale_r});
  assign diff      = {x_r[DATA_W-1], x_r} - {fo_r[DATA_W-1], fo_r};

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL0: begin
        mul_a = rate_r;
        mul_b = {1'b0, m_r[15:0]};
      end
      S_MUL1: begin
        mul_a = rate_r;
        mul_b = m_r[MAG_W-1:16];
      end
      S_MUL2: begin
        mul_a = a_r[MUL_A_W-1:0];
        mul_b = {1'b0, e_r};
      end
      S_MUL3: begin
        mul_a = {{(MUL_A_W-(A_W-MUL_A_W)){1'b0}}, a_r[A_W-1:MUL_A_W]};
        mul_b = {1'b0, e_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // step keeps the sign of the difference, then saturate to 32 bits
  always_comb begin
    step_s = $signed({2'b00, div_sts.quotient});
    if (neg_r) begin
      step_s = -step_s;
    end
    sum_s = $signed({{(QUO_W+2-DATA_W){fo_r[DATA_W-1]}}, fo_r}) + step_s;
    if ((&sum_s[QUO_W+1:DATA_W-1]) || !(|sum_s[QUO_W+1:DATA_W-1])) begin
      sat_v = sum_s[DATA_W-1:0];
    end else if (sum_s[QUO_W+1]) begin
      sat_v = DATA_MIN;
    end else begin
      sat_v = DATA_MAX;
    end
  end

  always_comb begin
    clamp_v = res_r;
    if (max_en_r && (clamp_v > max_lim_r)) begin
      clamp_v = max_lim_r;
    end
    if (min_en_r && (clamp_v < min_lim_r)) begin
      clamp_v = min_lim_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fo_nxt        = fo_r;
    last_nxt      = last_r;
    primed_nxt    = primed_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    restart_nxt   = restart_r;
    rate_nxt      = rate_r;
    neg_nxt       = neg_r;
    m_nxt         = m_r;
    a_nxt         = a_r;
    q_nxt         = q_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_req.start    = 1'b0;
    div_req.dividend = q_r + {prod[PROD_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt      = in_sample;
          last_nxt   = in_timestamp_ms;
          primed_nxt = 1'b1;
          e_nxt      = (elapsed == '0) ? STALE_W'(1) : elapsed[STALE_W-1:0];
          if (!primed_r || stale_gap) begin
            res_nxt     = in_sample;
            restart_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            restart_nxt = 1'b0;
            state_nxt   = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        neg_nxt   = diff[MAG_W-1];
        rate_nxt  = (diff > 0) ? rise_r : fall_r;
        m_nxt     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        a_nxt     = A_W'(prod >> 16);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        a_nxt     = a_r + prod[A_W-1:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        q_nxt     = PROD_W'(prod);
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        res_nxt   = sat_v;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        res_nxt   = clamp_v;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          fo_nxt        = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fo_r        <= '0;
      last_r      <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      restart_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fo_r        <= fo_nxt;
      last_r      <= last_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      restart_r   <= restart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    e_r        <= e_nxt;
    rate_r     <= rate_nxt;
    neg_r      <= neg_nxt;
    m_r        <= m_nxt;
    a_r        <= a_nxt;
    q_r        <= q_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r    <= RISE_RATE_RST;
      fall_r    <= FALL_RATE_RST;
      max_lim_r <= DATA_MAX;
      min_lim_r <= DATA_MIN;
      max_en_r  <= 1'b0;
      min_en_r  <= 1'b0;
      stale_r   <= STALE_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RISE_RATE:  rise_r    <= cfg_data[RATE_W-1:0];
        CFG_FALL_RATE:  fall_r    <= cfg_data[RATE_W-1:0];
        CFG_MAX_LIMIT:  max_lim_r <= $signed(cfg_data);
        CFG_MIN_LIMIT:  min_lim_r <= $signed(cfg_data);
        CFG_MAX_ENABLE: max_en_r  <= cfg_data[0];
        CFG_MIN_ENABLE: min_en_r  <= cfg_data[0];
        CFG_STALE_MS:   stale_r   <= cfg_data[STALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  alcf_div1000 u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_sts (div_sts)
  );

  `ALCF_ASSERT(a_restart_direct, in_fire && (!primed_r || stale_gap) |=> (state_r == S_DONE) && restart_r, "restart request did not go straight to result")
  `ALCF_ASSERT(a_div_done_state, div_sts.done |-> (state_r == S_DIV), "divider finished outside divide state")
  `ALCF_ASSERT(a_min_clamp, (state_r == S_DONE) && !restart_r && min_en_r |-> (res_r >= min_lim_r), "result below enabled min limit")
  `ALCF_ASSERT(a_max_clamp, (state_r == S_DONE) && !restart_r && max_en_r && !(min_en_r && (min_lim_r > max_lim_r)) |-> (res_r <= max_lim_r), "result above enabled max limit")
  `ALCF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && in_ready, "not quiet after reset")

endmodule

### sv/alcf_div1000.sv
`timescale 1ns / 1ps
module alcf_div1000 import alcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_sts_t div_sts
);

  logic [PROD_W-1:0]     sh_r, sh_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [REM_W:0]        work;
  logic [DIGIT_BITS-1:0] qd;

  // one radix-16 digit per cycle, restoring
  always_comb begin
    work = {1'b0, rem_r};
    qd   = '0;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      work = {work[REM_W-1:0], sh_r[PROD_W-1-k]};
      if (work >= (REM_W+1)'(DIVISOR)) begin
        work = work - (REM_W+1)'(DIVISOR);
        qd[DIGIT_BITS-1-k] = 1'b1;
      end
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (div_req.start) begin
      sh_nxt   = div_req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[PROD_W-DIGIT_BITS-1:0], qd};
      rem_nxt = work[REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign div_sts.busy     = busy_r;
  assign div_sts.done     = done_r;
  assign div_sts.quotient = sh_r[QUO_W-1:0];

endmodule
